// ===== sv/gsq_pkg.sv =====
// ---------------------------------------------------------------------------
// gsq_pkg: shared types and constants of the gather send queue
// Request and status codes, field widths and parameter defaults.
// ---------------------------------------------------------------------------
package gsq_pkg;

    // Parameter defaults
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_LEN_BITS    = 16;
    localparam int DEF_ADDR_BITS   = 32;

    // Fixed field widths of the stream words
    localparam int PEND_BITS     = 20;
    localparam int SEG_ADDR_BITS = 32;
    localparam int SEG_LEN_BITS  = 16;
    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_DATA_BITS = 72;

    // Most slices one gather emits
    localparam int RESULT_LIMIT = 16;

    // Largest pending byte total
    localparam logic [PEND_BITS-1:0] PENDING_MAX = '1;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_GATHER  = 2'd1,
        REQ_CONSUME = 2'd2
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_OVER  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

endpackage

// ===== sv/gather_send_queue_unit.sv =====
// ---------------------------------------------------------------------------
// gather_send_queue_unit: scatter/gather descriptor queue
// FIFO of (address, length) descriptors with head offset and pending count.
// ---------------------------------------------------------------------------
// One request word is taken at a time. An append, a rejected request or an
// unknown kind goes from the cycle in which the word is taken to a decode
// state that loads its single answer word. A gather likewise takes the word
// and decodes it, and the decode also issues the first descriptor read; then
// it emits one slice word per cycle while the output is not held, at most 16
// slices. A consume, after its decode, walks the descriptors it touches, one
// per cycle through the single read port of the descriptor memory, and then
// loads the answer word. The block takes its next request while the last
// answer still waits in the output register; output back-pressure stalls the
// decode, the slice walk and the answer load.
// Descriptor entries hold garbage until appended and need no clearing.
module gather_send_queue_unit #(
    parameter int QUEUE_DEPTH = gsq_pkg::DEF_QUEUE_DEPTH,
    parameter int LEN_BITS    = gsq_pkg::DEF_LEN_BITS,
    parameter int ADDR_BITS   = gsq_pkg::DEF_ADDR_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: buf_addr[31:0], buf_len[47:32], byte_count[67:48], zero fill
    input  logic [gsq_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                        s_axis_tuser,
    // Result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: seg_addr[31:0], seg_len[47:32], pending_bytes[67:48], zero fill
    output logic [gsq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                              m_axis_tlast,
    // tuser: status[1:0]
    output logic [1:0]                        m_axis_tuser
);

    import gsq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SL_W  = $clog2(RESULT_LIMIT + 1);
    localparam int CMP_W = (LEN_BITS > PEND_BITS) ? LEN_BITS : PEND_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_GWALK = 4'b0100,
        S_CWALK = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           req_type_reg;
    logic [ADDR_BITS-1:0] buf_addr_reg;
    logic [LEN_BITS-1:0]  buf_len_reg;
    logic [PEND_BITS-1:0] byte_count_reg;

    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [LEN_BITS-1:0]  offset_reg, offset_next;
    logic [PEND_BITS-1:0] pending_reg, pending_next;

    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [PEND_BITS-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [SL_W-1:0]      nslice_reg, nslice_next;
    logic                 first_reg, first_next;

    logic                     out_valid_reg, out_valid_next;
    logic [SEG_ADDR_BITS-1:0] out_addr_reg, out_addr_next;
    logic [SEG_LEN_BITS-1:0]  out_len_reg, out_len_next;
    logic                     out_last_reg, out_last_next;
    status_t                  out_status_reg, out_status_next;
    logic [PEND_BITS-1:0]     out_pend_reg, out_pend_next;

    logic                 wr_en;
    logic [ADDR_BITS-1:0] rd_desc_addr;
    logic [LEN_BITS-1:0]  rd_desc_len;

    logic                 in_accept;
    logic                 slot_free;
    logic                 out_load;
    logic                 use_offset;
    logic [LEN_BITS-1:0]  avail;
    logic [CMP_W-1:0]     avail_w;
    logic [CMP_W-1:0]     rem_w;
    logic                 avail_le;
    logic [CMP_W-1:0]     take_w;
    logic [PEND_BITS-1:0] take_p;
    logic [PEND_BITS-1:0] rem_after;
    logic [CNT_W-1:0]     pos_inc;
    logic [SL_W-1:0]      nslice_inc;
    logic                 more;
    logic [ADDR_BITS-1:0] slice_addr;
    logic [CMP_W:0]       append_sum;
    logic                 over;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        next_idx = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign slot_free = !out_valid_reg || m_axis_tready;

    // Slice and retire datapath on the descriptor being read
    assign use_offset = first_reg || (state_reg == S_CWALK);
    assign avail      = rd_desc_len - (use_offset ? offset_reg : '0);
    assign avail_w    = CMP_W'(avail);
    assign rem_w      = CMP_W'(rem_reg);
    assign avail_le   = avail_w <= rem_w;
    assign take_w     = avail_le ? avail_w : rem_w;
    assign take_p     = PEND_BITS'(take_w);
    assign rem_after  = rem_reg - take_p;
    assign pos_inc    = pos_reg + 1'b1;
    assign nslice_inc = nslice_reg + 1'b1;
    assign more       = (pos_inc < count_reg) && (rem_after != '0)
                        && (nslice_inc < SL_W'(RESULT_LIMIT));
    assign slice_addr = rd_desc_addr + (first_reg ? ADDR_BITS'(offset_reg) : '0);

    // Append bound and request-beyond-pending checks
    assign append_sum = (CMP_W + 1)'(pending_reg) + (CMP_W + 1)'(buf_len_reg);
    assign over       = byte_count_reg > pending_reg;

    // Sequence one request
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        offset_next     = offset_reg;
        pending_next    = pending_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        nslice_next     = nslice_reg;
        first_next      = first_reg;
        wr_en           = 1'b0;
        out_load        = 1'b0;
        out_addr_next   = out_addr_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_pend_next   = out_pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                out_addr_next   = '0;
                out_len_next    = '0;
                out_last_next   = 1'b1;
                out_status_next = STAT_OK;
                out_pend_next   = pending_reg;
                case (req_type_reg)
                    REQ_APPEND:
                    begin
                        if (slot_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (buf_len_reg == '0)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else if (count_reg == CNT_W'(QUEUE_DEPTH)
                                     || append_sum > (CMP_W + 1)'(PENDING_MAX))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                tail_next     = next_idx(tail_reg);
                                count_next    = count_reg + 1'b1;
                                pending_next  = PEND_BITS'(append_sum);
                                out_pend_next = PEND_BITS'(append_sum);
                            end
                        end
                    end

                    REQ_GATHER, REQ_CONSUME:
                    begin
                        if (over)
                        begin
                            out_status_next = STAT_OVER;
                            if (slot_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (req_type_reg == REQ_GATHER && count_reg == '0)
                        begin
                            if (slot_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next    = head_reg;
                            rem_next    = byte_count_reg;
                            pos_next    = '0;
                            nslice_next = '0;
                            first_next  = (req_type_reg == REQ_GATHER);
                            state_next  = (req_type_reg == REQ_GATHER) ? S_GWALK
                                                                      : S_CWALK;
                        end
                    end

                    default:
                    begin
                        if (slot_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_GWALK:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_addr_next   = SEG_ADDR_BITS'(slice_addr);
                    out_len_next    = SEG_LEN_BITS'(take_w);
                    out_last_next   = !more;
                    out_status_next = STAT_OK;
                    out_pend_next   = pending_reg;
                    if (more)
                    begin
                        idx_next    = next_idx(idx_reg);
                        rem_next    = rem_after;
                        pos_next    = pos_inc;
                        nslice_next = nslice_inc;
                        first_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_CWALK:
            begin
                if (count_reg == '0 || rem_reg == '0)
                begin
                    out_addr_next   = '0;
                    out_len_next    = '0;
                    out_last_next   = 1'b1;
                    out_status_next = STAT_OK;
                    out_pend_next   = pending_reg;
                    if (slot_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // Retire the head entry or advance into it
                    pending_next = pending_reg - take_p;
                    rem_next     = rem_after;
                    if (avail_le)
                    begin
                        offset_next = '0;
                        head_next   = next_idx(head_reg);
                        idx_next    = next_idx(idx_reg);
                        count_next  = count_reg - 1'b1;
                    end
                    else
                    begin
                        offset_next = offset_reg + LEN_BITS'(take_w);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            pending_reg   <= '0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            pos_reg       <= '0;
            nslice_reg    <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            offset_reg    <= offset_next;
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            nslice_reg    <= nslice_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request word and hold the result word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            buf_addr_reg   <= ADDR_BITS'(s_axis_tdata[31:0]);
            buf_len_reg    <= LEN_BITS'(s_axis_tdata[47:32]);
            byte_count_reg <= s_axis_tdata[67:48];
            req_type_reg   <= s_axis_tuser;
        end
        if (out_load)
        begin
            out_addr_reg   <= out_addr_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
            out_pend_reg   <= out_pend_next;
        end
    end

    // Descriptor memory: read address follows the walk index
    gsq_desc_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEN_BITS    (LEN_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .IDX_W       (IDX_W)
    ) u_desc_mem (
        .clk          (clk),
        .wr_en        (wr_en),
        .wr_index     (tail_reg),
        .wr_desc_addr (buf_addr_reg),
        .wr_desc_len  (buf_len_reg),
        .rd_index     (idx_next),
        .rd_desc_addr (rd_desc_addr),
        .rd_desc_len  (rd_desc_len)
    );

    // Drive the stream ports
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_pend_reg, out_len_reg, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (pending_reg == '0 && offset_reg == '0))
        else $error("empty queue with pending bytes or head offset");

    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_EXEC && req_type_reg == REQ_APPEND))
        else $error("descriptor write outside append");

    a_cwalk_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CWALK) |-> (idx_reg == head_reg))
        else $error("consume walk index lost the head");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> ($stable(out_addr_reg)
            && $stable(out_pend_reg) && $stable(out_last_reg)))
        else $error("held result word overwritten");
`endif

endmodule

// ===== sv/gsq_desc_mem.sv =====
// ---------------------------------------------------------------------------
// gsq_desc_mem: descriptor storage
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module gsq_desc_mem #(
    parameter int QUEUE_DEPTH = gsq_pkg::DEF_QUEUE_DEPTH,
    parameter int LEN_BITS    = gsq_pkg::DEF_LEN_BITS,
    parameter int ADDR_BITS   = gsq_pkg::DEF_ADDR_BITS,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_index,
    input  logic [ADDR_BITS-1:0] wr_desc_addr,
    input  logic [LEN_BITS-1:0]  wr_desc_len,
    input  logic [IDX_W-1:0]     rd_index,
    output logic [ADDR_BITS-1:0] rd_desc_addr,
    output logic [LEN_BITS-1:0]  rd_desc_len
);

    logic [ADDR_BITS-1:0] addr_mem [QUEUE_DEPTH];
    logic [LEN_BITS-1:0]  len_mem  [QUEUE_DEPTH];

    // Write the appended descriptor
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_mem[wr_index] <= wr_desc_addr;
            len_mem[wr_index]  <= wr_desc_len;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rd_desc_addr <= addr_mem[rd_index];
        rd_desc_len  <= len_mem[rd_index];
    end

endmodule
